/* rtl/assert_macros.svh */
// assertion helpers included by the top-level rtl file
// both expect clk_i and rst_ni in the scope where they are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising edge outside reset
`define TCW_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// same-cycle implication checked outside reset
`define TCW_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/tcw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // screen geometry defaults
  localparam int DefColumns = 80;
  localparam int DefRows    = 25;

  // fixed field widths of the words
  localparam int CharW      = 8;
  localparam int CursorRowW = 5;
  localparam int CursorColW = 7;
  localparam int CellW      = 16;

  localparam logic [CharW-1:0] FallbackAttrReset = 8'h0f;

  // operation codes
  localparam logic OpPut  = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef struct packed {
    logic                  operation;
    logic [CharW-1:0]      character;
    logic                  string_start;
    logic [CursorRowW-1:0] read_row;
    logic [CursorColW-1:0] read_col;
  } in_word_t;

  typedef struct packed {
    logic [CharW-1:0]      cell_char;
    logic [CharW-1:0]      cell_attr;
    logic [CursorRowW-1:0] cursor_row;
    logic [CursorColW-1:0] cursor_col;
    logic                  wrote_cell;
    logic                  scrolled;
  } out_word_t;

  // commands from the engine to the screen store
  typedef struct packed {
    logic wr_en;
    logic clr_en;
    logic rd_en;
  } scr_ctl_t;

endpackage

`default_nettype wire

/* rtl/tcw_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_engine #(
  parameter int COLUMNS = tcw_pkg::DefColumns,
  parameter int ROWS    = tcw_pkg::DefRows,
  parameter int RowW    = $clog2(ROWS),
  parameter int ColW    = $clog2(COLUMNS)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      adv_i,
  input  wire tcw_pkg::in_word_t         item_i,
  input  wire logic [tcw_pkg::CharW-1:0] fallback_i,
  output logic [RowW-1:0]                cursor_row_o,
  output logic [ColW-1:0]                cursor_col_o,
  output logic                           wrote_o,
  output logic                           scrolled_o,
  output logic [RowW-1:0]                top_row_o,
  output tcw_pkg::scr_ctl_t              ctl_o,
  output logic [RowW-1:0]                wr_row_o,
  output logic [ColW-1:0]                wr_col_o,
  output logic [tcw_pkg::CellW-1:0]      wr_data_o,
  output logic [RowW-1:0]                clr_row_o
);
  import tcw_pkg::*;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhFg   = 2'd1;
  localparam logic [1:0] PhBg   = 2'd2;

  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChX         = 8'h78;
  localparam logic [7:0] ChNewline   = 8'h0a;
  localparam logic [7:0] Ch0         = 8'h30;
  localparam logic [7:0] Ch7         = 8'h37;
  localparam logic [7:0] Ch9         = 8'h39;
  localparam logic [7:0] ChA         = 8'h61;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] NulChar     = 8'h00;

  localparam logic [RowW-1:0] LastRow = RowW'(ROWS - 1);
  localparam logic [ColW-1:0] LastCol = ColW'(COLUMNS - 1);

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h0f;
      if (c >= Ch0 && c <= Ch9) begin
        d = c - Ch0;
      end else if (c >= ChA && c <= ChF) begin
        d = c - ChA + 8'd10;
      end
      return d[3:0];
    end
  endfunction

  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] top_q, top_d;
  logic [3:0]      fg_q, fg_d;
  logic [2:0]      bg_q, bg_d;
  logic [1:0]      phase_q, phase_d;

  logic [3:0]      fg_s;
  logic [2:0]      bg_s;
  logic [1:0]      phase_s;
  logic            wrote, scrolled;
  logic [7:0]      attr, bg_ch;
  logic [RowW:0]   wr_sum;

  // physical row of the cursor: top plus cursor, wrapped once
  always_comb begin
    wr_sum = {1'b0, top_q} + {1'b0, row_q};
    if (wr_sum >= (RowW+1)'(ROWS)) begin
      wr_sum = wr_sum - (RowW+1)'(ROWS);
    end
  end

  always_comb begin
    attr = {1'b0, bg_s, fg_s};
    if (attr == 8'h00) begin
      attr = fallback_i;
    end
  end

  assign bg_ch = item_i.character - Ch0;

  always_comb begin
    fg_s    = item_i.string_start ? 4'hf : fg_q;
    bg_s    = item_i.string_start ? 3'd0 : bg_q;
    phase_s = item_i.string_start ? PhIdle : phase_q;

    fg_d     = fg_s;
    bg_d     = bg_s;
    phase_d  = phase_s;
    row_d    = row_q;
    col_d    = col_q;
    top_d    = top_q;
    wrote    = 1'b0;
    scrolled = 1'b0;

    if (item_i.operation == OpPut) begin
      case (phase_s)
        PhFg: begin
          if (item_i.character == ChX) begin
            fg_d    = 4'hf;
            bg_d    = 3'd0;
            phase_d = PhIdle;
          end else begin
            fg_d    = hex_value(item_i.character);
            phase_d = PhBg;
          end
        end
        PhBg: begin
          if (item_i.character != NulChar) begin
            bg_d = (item_i.character >= Ch0 && item_i.character <= Ch7) ? bg_ch[2:0] : 3'd0;
          end
          phase_d = PhIdle;
        end
        PhIdle: begin
          if (item_i.character == ChBackslash) begin
            phase_d = PhFg;
          end else if (item_i.character != NulChar) begin
            logic newline;
            newline = 1'b1;
            if (item_i.character != ChNewline) begin
              wrote = 1'b1;
              if (col_q != LastCol) begin
                newline = 1'b0;
                col_d   = col_q + 1'b1;
              end
            end
            if (newline) begin
              col_d = '0;
              if (row_q == LastRow) begin
                scrolled = 1'b1;
                top_d    = (top_q == LastRow) ? '0 : top_q + 1'b1;
              end else begin
                row_d = row_q + 1'b1;
              end
            end
          end
        end
        default: begin
          phase_d = phase_s;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      top_q   <= '0;
      fg_q    <= 4'hf;
      bg_q    <= 3'd0;
      phase_q <= PhIdle;
    end else if (adv_i) begin
      row_q   <= row_d;
      col_q   <= col_d;
      top_q   <= top_d;
      fg_q    <= fg_d;
      bg_q    <= bg_d;
      phase_q <= phase_d;
    end
  end

  assign cursor_row_o = row_d;
  assign cursor_col_o = col_d;
  assign wrote_o      = wrote;
  assign scrolled_o   = scrolled;
  assign top_row_o    = top_q;

  // the row that scrolls in is the old top row
  assign ctl_o.wr_en  = wrote;
  assign ctl_o.clr_en = scrolled;
  assign ctl_o.rd_en  = (item_i.operation == OpRead);
  assign wr_row_o     = wr_sum[RowW-1:0];
  assign wr_col_o     = col_q;
  assign wr_data_o    = {attr, item_i.character};
  assign clr_row_o    = top_q;

endmodule

`default_nettype wire

/* rtl/tcw_screen.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_screen #(
  parameter int COLUMNS = tcw_pkg::DefColumns,
  parameter int ROWS    = tcw_pkg::DefRows,
  parameter int RowW    = $clog2(ROWS),
  parameter int ColW    = $clog2(COLUMNS)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           adv_i,
  input  wire tcw_pkg::scr_ctl_t              ctl_i,
  input  wire logic [RowW-1:0]                wr_row_i,
  input  wire logic [ColW-1:0]                wr_col_i,
  input  wire logic [tcw_pkg::CellW-1:0]      wr_data_i,
  input  wire logic [RowW-1:0]                clr_row_i,
  input  wire logic [RowW-1:0]                top_row_i,
  input  wire logic [tcw_pkg::CursorRowW-1:0] rd_row_i,
  input  wire logic [tcw_pkg::CursorColW-1:0] rd_col_i,
  output logic [tcw_pkg::CellW-1:0]           cell_o
);
  import tcw_pkg::*;

  localparam int Depth = ROWS * COLUMNS;
  localparam int AddrW = $clog2(Depth);
  localparam int FillW = $clog2(COLUMNS + 1);

  // cells written since each row was last blanked form columns 0 up to fill - 1
  logic [FillW-1:0] fill_q [ROWS];
  logic [CellW-1:0] cells_q [Depth];
  logic [CellW-1:0] rdata_q;
  logic             cell_ok_q;

  logic [RowW:0]    rd_sum;
  logic [RowW-1:0]  rd_phys;
  logic [ColW-1:0]  rd_col;
  logic             rd_ok;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic             wr_go, rd_go;

  always_comb begin
    rd_sum = {1'b0, top_row_i} + (RowW+1)'(rd_row_i);
    if (rd_sum >= (RowW+1)'(ROWS)) begin
      rd_sum = rd_sum - (RowW+1)'(ROWS);
    end
  end

  assign rd_phys = rd_sum[RowW-1:0];
  assign rd_col  = ColW'(rd_col_i);
  assign rd_ok   = (rd_row_i < ROWS) && (rd_col_i < COLUMNS)
                   && (FillW'(rd_col) < fill_q[rd_phys]);
  assign rd_addr = AddrW'(rd_phys) * AddrW'(COLUMNS) + AddrW'(rd_col);
  assign wr_addr = AddrW'(wr_row_i) * AddrW'(COLUMNS) + AddrW'(wr_col_i);
  assign wr_go   = adv_i && ctl_i.wr_en;
  assign rd_go   = adv_i && ctl_i.rd_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        fill_q[r] <= '0;
      end
    end else if (adv_i) begin
      if (ctl_i.clr_en) begin
        fill_q[clr_row_i] <= '0;
      end
      if (ctl_i.wr_en) begin
        fill_q[wr_row_i] <= FillW'(wr_col_i) + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_go) begin
      cells_q[wr_addr] <= wr_data_i;
    end
    if (rd_go) begin
      rdata_q <= cells_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_ok_q <= 1'b0;
    end else if (adv_i) begin
      cell_ok_q <= ctl_i.rd_en && rd_ok;
    end
  end

  assign cell_o = cell_ok_q ? rdata_q : '0;

endmodule

`default_nettype wire

/* rtl/text_console_char_writer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Text console engine. Each input word either puts one character through the
// escape parser (backslash x resets the colour, backslash fg bg picks a
// foreground hex digit and a background digit, newline moves down, other
// nonzero bytes are stored with the current attribute) or reads one visible
// cell, and each word gives exactly one output word with the cursor after it.
// Throughput is one word per clock unless the output stalls: a word sits in
// the input register, where the parser, cursor and store updates happen, and
// the result lands in the output register while the next word is taken in.
// Scrolling is a top-row pointer move, and a per-row fill count masks cells
// not written since the row was blanked, so no clearing pass is needed after
// reset or on scroll. The user must write the fallback attribute through
// cfg_we_i / cfg_data_i only while idle; the block does not enforce this.
module text_console_char_writer_unit #(
  parameter int COLUMNS = tcw_pkg::DefColumns,
  parameter int ROWS    = tcw_pkg::DefRows
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [tcw_pkg::CharW-1:0] cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire tcw_pkg::in_word_t         in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output tcw_pkg::out_word_t             out_data_o
);
  import tcw_pkg::*;

  `include "assert_macros.svh"

  localparam int RowW = $clog2(ROWS);
  localparam int ColW = $clog2(COLUMNS);

  // input register and output register with their valid flags
  in_word_t         in_q;
  logic             in_valid_q;
  out_word_t        out_q;
  logic             out_valid_q;
  logic [CharW-1:0] fallback_q;

  // the word in the input register moves to the output register
  logic adv;

  logic [RowW-1:0]  cur_row;
  logic [ColW-1:0]  cur_col;
  logic             wrote, scrolled;
  logic [RowW-1:0]  top_row;
  scr_ctl_t         scr_ctl;
  logic [RowW-1:0]  wr_row, clr_row;
  logic [ColW-1:0]  wr_col;
  logic [CellW-1:0] wr_data, rd_cell;

  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fallback_q <= FallbackAttrReset;
    end else if (cfg_we_i) begin
      fallback_q <= cfg_data_i;
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  tcw_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .RowW    (RowW),
    .ColW    (ColW)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .item_i       (in_q),
    .fallback_i   (fallback_q),
    .cursor_row_o (cur_row),
    .cursor_col_o (cur_col),
    .wrote_o      (wrote),
    .scrolled_o   (scrolled),
    .top_row_o    (top_row),
    .ctl_o        (scr_ctl),
    .wr_row_o     (wr_row),
    .wr_col_o     (wr_col),
    .wr_data_o    (wr_data),
    .clr_row_o    (clr_row)
  );

  // cell store, read data comes out registered along with the output word
  tcw_screen #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .RowW    (RowW),
    .ColW    (ColW)
  ) u_screen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .ctl_i     (scr_ctl),
    .wr_row_i  (wr_row),
    .wr_col_i  (wr_col),
    .wr_data_i (wr_data),
    .clr_row_i (clr_row),
    .top_row_i (top_row),
    .rd_row_i  (in_q.read_row),
    .rd_col_i  (in_q.read_col),
    .cell_o    (rd_cell)
  );

  // output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.cell_char  <= '0;
      out_q.cell_attr  <= '0;
      out_q.cursor_row <= CursorRowW'(cur_row);
      out_q.cursor_col <= CursorColW'(cur_col);
      out_q.wrote_cell <= wrote;
      out_q.scrolled   <= scrolled;
    end
  end

  // cell fields come straight from the store's read register
  always_comb begin
    out_data_o           = out_q;
    out_data_o.cell_char = rd_cell[CharW-1:0];
    out_data_o.cell_attr = rd_cell[CellW-1:CharW];
  end

  assign out_valid_o = out_valid_q;

  `TCW_ASSERT(a_cursor_in_range,
    !out_valid_o || (out_data_o.cursor_row < ROWS && out_data_o.cursor_col < COLUMNS))
  `TCW_ASSERT_IMPL(a_scroll_on_last_row, out_valid_o && out_data_o.scrolled,
    out_data_o.cursor_row == CursorRowW'(ROWS - 1) && out_data_o.cursor_col == '0)
  `TCW_ASSERT_IMPL(a_put_reads_no_cell, out_valid_o && out_data_o.wrote_cell,
    out_data_o.cell_char == '0 && out_data_o.cell_attr == '0)
  `TCW_ASSERT_IMPL(a_stall_means_full, !in_ready_o, in_valid_q && out_valid_q)

endmodule

`default_nettype wire
